// File: hdl/nc3_pkg.sv
// ---------------------------------------------------------------------------
// nc3_pkg
// Shared widths, register indexes and control types of the normalized
// 3x3 convolution block.
// ---------------------------------------------------------------------------
package nc3_pkg;

  // image geometry
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);   // column counter / line store address
  localparam int ROW_W      = $clog2(MAX_HEIGHT);  // row counter
  localparam int IMG_W_BITS = 12;                  // image_width register
  localparam int IMG_H_BITS = 13;                  // image_height register

  // arithmetic widths
  localparam int PIX_W     = 8;
  localparam int COEF_BITS = 16;
  localparam int CFG_W     = 3 * COEF_BITS;        // one packed kernel row
  localparam int PROD_W    = PIX_W + 1 + COEF_BITS;
  localparam int SUM_W     = 28;                   // 255 * 9 * 32768 fits signed
  localparam int MAG_W     = SUM_W - 1;
  localparam int ASUM_W    = 19;                   // 9 * 32768 fits
  localparam int QUO_W     = 17;                   // rounded quotient magnitude
  localparam int NUM_W     = MAG_W + 9;            // mag * 512 + asum
  localparam int DEN_W     = ASUM_W + 1;           // 2 * asum
  localparam int TAPS      = 9;
  localparam int TAP_IDX_W = $clog2(TAPS);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_MID    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 3'd4;

  // multiply-accumulate control
  typedef struct packed {
    logic clear;
    logic en;
  } nc3_mac_ctrl_t;

  // divider handshake status
  typedef struct packed {
    logic busy;
    logic done;
  } nc3_div_stat_t;

endpackage

// File: hdl/nc3_line_mem.sv
// ---------------------------------------------------------------------------
// nc3_line_mem
// Line store memory: each word holds the upper and lower line pixel of one
// column. One write port, one registered read port.
// ---------------------------------------------------------------------------
module nc3_line_mem
  import nc3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [COL_W-1:0]     rd_addr,
  output logic [2*PIX_W-1:0]   rd_data,
  input  logic                 wr_en,
  input  logic [COL_W-1:0]     wr_addr,
  input  logic [2*PIX_W-1:0]   wr_data
);

  logic [2*PIX_W-1:0] mem [MAX_WIDTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/nc3_mac.sv
// ---------------------------------------------------------------------------
// nc3_mac
// Shared multiply-accumulate unit: one kernel tap per cycle while en is high, also sums the
// absolute coefficient values for normalization.
// ---------------------------------------------------------------------------
module nc3_mac
  import nc3_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  nc3_mac_ctrl_t               ctrl,
  input  logic [PIX_W-1:0]            tap,
  input  logic signed [COEF_BITS-1:0] coef,
  output logic signed [SUM_W-1:0]     sum_r,
  output logic [ASUM_W-1:0]           asum_r
);

  logic signed [PROD_W-1:0]     prod;
  logic signed [COEF_BITS:0]    coef_x;
  logic [COEF_BITS:0]           coef_abs;
  logic signed [SUM_W-1:0]      sum_nxt;
  logic [ASUM_W-1:0]            asum_nxt;

  // product and absolute coefficient
  always_comb begin
    prod     = $signed({1'b0, tap}) * coef;
    coef_x   = (COEF_BITS+1)'(coef);
    coef_abs = coef_x[COEF_BITS] ? unsigned'(-coef_x) : unsigned'(coef_x);
  end

  // accumulate
  always_comb begin
    sum_nxt  = sum_r;
    asum_nxt = asum_r;
    if (ctrl.clear) begin
      sum_nxt  = '0;
      asum_nxt = '0;
    end else if (ctrl.en) begin
      sum_nxt  = sum_r + SUM_W'(prod);
      asum_nxt = asum_r + ASUM_W'(coef_abs);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      asum_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      asum_r <= asum_nxt;
    end
  end

endmodule

// File: hdl/nc3_div.sv
// ---------------------------------------------------------------------------
// nc3_div
// Iterative restoring divider: computes round(mag * 256 / asum) with ties
// away from zero as (mag * 512 + asum) / (2 * asum), one quotient bit a cycle.
// ---------------------------------------------------------------------------
module nc3_div
  import nc3_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MAG_W-1:0]   mag,
  input  logic [ASUM_W-1:0]  asum,
  output nc3_div_stat_t      stat,
  output logic [QUO_W-1:0]   quo
);

  localparam int CNT_W = $clog2(QUO_W);

  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // numerator; its top bits already sit below the divisor since quo < 2^QUO_W
  assign num = {mag, 9'd0} + NUM_W'(asum);

  // one restoring step
  always_comb begin
    trial   = {rem_r, quo_r[QUO_W-1]};
    diff    = trial - {1'b0, den_r};
    fits    = (trial >= {1'b0, den_r});
    rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    quo_nxt = {quo_r[QUO_W-2:0], fits};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        done_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          done_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(num[NUM_W-1:QUO_W]);
      quo_r <= num[QUO_W-1:0];
      den_r <= {asum, 1'b0};
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

endmodule

// File: hdl/normalized_conv3x3_top.sv
// ---------------------------------------------------------------------------
// normalized_conv3x3_top
// 3x3 true convolution of a raster grayscale stream, normalized by the sum of
// absolute kernel coefficients; emits interior pixels only.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------
//  in_     | in  | in_tvalid/in_tready   | tdata: pixel[7:0]
//  out_    | out | out_tvalid/out_tready | tdata: conv_value, out_row, out_col;
//          |     |                       | tlast: frame_last; tuser: zero_kernel
//  cfg_    | in  | cfg_we                | cfg_index selects register, cfg_wdata
//
//  A border pixel goes through accept and the line store read-modify-write.
//  An interior pixel adds nine taps through the single multiply-accumulate
//  unit and 17 steps of the bit-serial divider; a zero kernel skips the divider.
//  The result sits in an output register, so a new pixel is taken while it
//  waits; a stalled output holds the pipe only when the next result is ready.
//  Reset clears counters, window, kernel and control state; line stores need none.
//
module normalized_conv3x3_top
  import nc3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,     // [7:0] pixel
  // result output
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,    // [16:0] conv_value, [28:17] out_row,
                                              // [39:29] out_col
  output logic                  out_tlast,
  output logic                  out_tuser,    // [0] zero_kernel
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_MAC   = 6'b000100,
    S_SETUP = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } nc3_state_t;

  nc3_state_t state_r, state_nxt;

  // configuration registers
  logic [CFG_W-1:0]      row_top_r, row_mid_r, row_bottom_r;
  logic [IMG_W_BITS-1:0] img_width_r;
  logic [IMG_H_BITS-1:0] img_height_r;

  // position counters
  logic [COL_W-1:0] col_count_r;
  logic [ROW_W-1:0] row_count_r;

  // per-pixel context
  logic [PIX_W-1:0] pix_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             emit_r;
  logic             last_r;

  // window, tap counters, result
  logic [PIX_W-1:0] win_r [TAPS];
  logic [1:0]       ka_r, kb_r;
  logic             sign_r;
  logic             zk_r;
  logic [QUO_W-1:0] val_r;

  // output register
  logic             out_valid_r;
  logic [QUO_W-1:0] out_val_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_last_r;
  logic             out_zk_r;

  logic                  in_acc;
  logic                  out_free;
  logic [IMG_W_BITS-1:0] w_eff;
  logic [IMG_H_BITS-1:0] h_eff;
  logic [COL_W-1:0]      w_last;
  logic [ROW_W-1:0]      h_last;
  logic [COL_W-1:0]      c_eff;
  logic [ROW_W-1:0]      r_eff;

  logic [2*PIX_W-1:0]    mem_rd;
  logic [TAP_IDX_W-1:0]  tap_base, tap_idx;
  logic [CFG_W-1:0]      row_sel;
  logic signed [COEF_BITS-1:0] coef_sel;
  nc3_mac_ctrl_t         mac_ctrl;
  logic signed [SUM_W-1:0] sum;
  logic [ASUM_W-1:0]     asum;
  logic [MAG_W-1:0]      mag;
  logic                  div_start;
  nc3_div_stat_t         div_stat;
  logic [QUO_W-1:0]      quo;

  assign in_acc   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_top_r    <= '0;
      row_mid_r    <= '0;
      row_bottom_r <= '0;
      img_width_r  <= IMG_W_BITS'(640);
      img_height_r <= IMG_H_BITS'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_TOP:    row_top_r    <= cfg_wdata;
        REG_ROW_MID:    row_mid_r    <= cfg_wdata;
        REG_ROW_BOTTOM: row_bottom_r <= cfg_wdata;
        REG_IMG_WIDTH:  img_width_r  <= cfg_wdata[IMG_W_BITS-1:0];
        REG_IMG_HEIGHT: img_height_r <= cfg_wdata[IMG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry and current position
  always_comb begin
    if (img_width_r < IMG_W_BITS'(3)) begin
      w_eff = IMG_W_BITS'(3);
    end else if (img_width_r > IMG_W_BITS'(MAX_WIDTH)) begin
      w_eff = IMG_W_BITS'(MAX_WIDTH);
    end else begin
      w_eff = img_width_r;
    end
    if (img_height_r < IMG_H_BITS'(3)) begin
      h_eff = IMG_H_BITS'(3);
    end else if (img_height_r > IMG_H_BITS'(MAX_HEIGHT)) begin
      h_eff = IMG_H_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = img_height_r;
    end
    w_last = COL_W'(w_eff - 1'b1);
    h_last = ROW_W'(h_eff - 1'b1);
    c_eff  = (col_count_r > w_last) ? w_last : col_count_r;
    r_eff  = (row_count_r > h_last) ? h_last : row_count_r;
  end

  // raster counters and pixel context, taken at accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      emit_r      <= 1'b0;
      last_r      <= 1'b0;
    end else if (in_acc) begin
      emit_r <= (r_eff >= ROW_W'(2)) && (c_eff >= COL_W'(2));
      last_r <= (r_eff == h_last) && (c_eff == w_last);
      if (c_eff >= w_last) begin
        col_count_r <= '0;
        row_count_r <= (r_eff >= h_last) ? '0 : r_eff + 1'b1;
      end else begin
        col_count_r <= c_eff + 1'b1;
        row_count_r <= r_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r <= in_tdata[PIX_W-1:0];
      col_r <= c_eff;
      row_r <= r_eff;
    end
  end

  // line stores: read at accept, write back {lower, new pixel} next cycle
  nc3_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (c_eff),
    .rd_data (mem_rd),
    .wr_en   (state_r == S_READ),
    .wr_addr (col_r),
    .wr_data ({mem_rd[PIX_W-1:0], pix_r})
  );

  // window shift on every pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else if (state_r == S_READ) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i*3]     <= win_r[i*3 + 1];
        win_r[i*3 + 1] <= win_r[i*3 + 2];
      end
      win_r[2] <= mem_rd[2*PIX_W-1:PIX_W];
      win_r[5] <= mem_rd[PIX_W-1:0];
      win_r[8] <= pix_r;
    end
  end

  // tap select: coefficient (a,b) meets window entry (2-a, 2-b)
  always_comb begin
    case (ka_r)
      2'd0:    begin tap_base = TAP_IDX_W'(6); row_sel = row_top_r;    end
      2'd1:    begin tap_base = TAP_IDX_W'(3); row_sel = row_mid_r;    end
      default: begin tap_base = TAP_IDX_W'(0); row_sel = row_bottom_r; end
    endcase
    tap_idx = tap_base + TAP_IDX_W'(2'd2 - kb_r);
    case (kb_r)
      2'd0:    coef_sel = signed'(row_sel[COEF_BITS-1:0]);
      2'd1:    coef_sel = signed'(row_sel[2*COEF_BITS-1:COEF_BITS]);
      default: coef_sel = signed'(row_sel[3*COEF_BITS-1:2*COEF_BITS]);
    endcase
  end

  assign mac_ctrl.clear = (state_r == S_READ);
  assign mac_ctrl.en    = (state_r == S_MAC);

  nc3_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .tap    (win_r[tap_idx]),
    .coef   (coef_sel),
    .sum_r  (sum),
    .asum_r (asum)
  );

  // magnitude of the weighted sum
  assign mag       = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
  assign div_start = (state_r == S_SETUP) && (asum != '0);

  nc3_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (mag),
    .asum  (asum),
    .stat  (div_stat),
    .quo   (quo)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_READ;
      S_READ:  state_nxt = emit_r ? S_MAC : S_IDLE;
      S_MAC:   if (ka_r == 2'd2 && kb_r == 2'd2) state_nxt = S_SETUP;
      S_SETUP: state_nxt = (asum == '0) ? S_OUT : S_DIV;
      S_DIV:   if (div_stat.done) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // kernel row / column counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ka_r <= '0;
      kb_r <= '0;
    end else if (state_r == S_MAC) begin
      if (kb_r == 2'd2) begin
        kb_r <= '0;
        ka_r <= (ka_r == 2'd2) ? 2'd0 : ka_r + 1'b1;
      end else begin
        kb_r <= kb_r + 1'b1;
      end
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (state_r == S_SETUP) begin
      sign_r <= sum[SUM_W-1];
      zk_r   <= (asum == '0);
      val_r  <= '0;
    end else if (state_r == S_DIV && div_stat.done) begin
      val_r <= sign_r ? QUO_W'(-quo) : quo;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_val_r  <= val_r;
      out_row_r  <= row_r - 1'b1;
      out_col_r  <= col_r - 1'b1;
      out_last_r <= last_r;
      out_zk_r   <= zk_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_col_r, out_row_r, out_val_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_zk_r;

endmodule

// File: tb/normalized_conv3x3_top_tb.sv
// ----------------------------------------------------------------------------
// normalized_conv3x3_top_tb
// Self-checking bench for the normalized 3x3 convolution block. Raster pixel
// frames of many geometries and kernels stream in with random gaps; a line
// buffer model inside the scoreboard predicts each interior word, and every
// output word is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module normalized_conv3x3_top_tb;
  import nc3_pkg::*;

  localparam int SETTLE_CYCLES = 48;   // longer than one interior pixel
  localparam int TAIL_CYCLES   = 64;
  localparam int RANDOM_PIXELS = 400;
  localparam int HOLD_CYCLES   = 400;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_IMG_HEIGHT + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  typedef enum {KERN_FULL, KERN_SMALL, KERN_EDGE} kernel_mix_t;
  typedef enum {PIX_ANY, PIX_BLACK_WHITE, PIX_DARK, PIX_BRIGHT} pixel_mix_t;

  // one output word split into its fields
  typedef struct {
    logic signed [16:0] value;
    logic [11:0]        row;
    logic [10:0]        col;
    logic               last;
    logic               zero_k;
  } conv_word_t;

  // --------------------------------------------------------------------------
  // scoreboard: line buffer model of the block plus queue of expected words
  // --------------------------------------------------------------------------
  class conv_scoreboard;
    logic [CFG_W-1:0]      kernel_rows[3];
    logic [IMG_W_BITS-1:0] width_reg;
    logic [IMG_H_BITS-1:0] height_reg;
    bit [PIX_W-1:0]        upper_line[MAX_WIDTH];
    bit [PIX_W-1:0]        lower_line[MAX_WIDTH];
    bit [PIX_W-1:0]        win[9];   // win[i*3+j]: row r-2+i, column c-2+j
    int unsigned           col_cnt;
    int unsigned           row_cnt;
    conv_word_t            expected_words[$];
    int                    errors;

    function new();
      foreach (kernel_rows[i]) kernel_rows[i] = '0;
      foreach (win[i]) win[i] = '0;
      width_reg  = IMG_W_BITS'(640);
      height_reg = IMG_H_BITS'(480);
      col_cnt    = 0;
      row_cnt    = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_ROW_TOP:    kernel_rows[0] = data;
        REG_ROW_MID:    kernel_rows[1] = data;
        REG_ROW_BOTTOM: kernel_rows[2] = data;
        REG_IMG_WIDTH:  width_reg  = data[IMG_W_BITS-1:0];
        REG_IMG_HEIGHT: height_reg = data[IMG_H_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg < 3) return 3;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < 3) return 3;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    // pixels still needed to close the current frame
    function int unsigned pixels_left();
      int unsigned w, h, c, r;
      w = eff_width();
      h = eff_height();
      c = (col_cnt >= w) ? w - 1 : col_cnt;
      r = (row_cnt >= h) ? h - 1 : row_cnt;
      return (h - 1 - r) * w + (w - c);
    endfunction

    // advance the model by one accepted pixel word
    function void take_pixel(bit [PIX_W-1:0] pix);
      int unsigned w, h, c, r;
      bit [PIX_W-1:0] up, lo;
      logic signed [COEF_BITS-1:0] coef;
      longint acc, abs_sum, k, quo;
      conv_word_t word;
      w = eff_width();
      h = eff_height();
      // counters past a shrunken geometry close the row or frame
      c = (col_cnt >= w) ? w - 1 : col_cnt;
      r = (row_cnt >= h) ? h - 1 : row_cnt;

      up = upper_line[c];
      lo = lower_line[c];
      upper_line[c] = lo;
      lower_line[c] = pix;
      for (int i = 0; i < 3; i++) begin
        win[i*3]   = win[i*3+1];
        win[i*3+1] = win[i*3+2];
      end
      win[2] = up;
      win[5] = lo;
      win[8] = pix;

      if (r >= 2 && c >= 2) begin
        acc     = 0;
        abs_sum = 0;
        // flipped kernel: coefficient (a,b) meets pixel (y-a+1, x-b+1)
        for (int a = 0; a < 3; a++) begin
          for (int b = 0; b < 3; b++) begin
            coef = kernel_rows[a][b*COEF_BITS +: COEF_BITS];
            k = coef;
            acc += k * longint'(win[(2-a)*3 + (2-b)]);
            abs_sum += (k < 0) ? -k : k;
          end
        end
        word.zero_k = (abs_sum == 0);
        if (abs_sum == 0) begin
          word.value = '0;
        end else begin
          // round to nearest, ties away from zero
          quo = (((acc < 0) ? -acc : acc) * 512 + abs_sum) / (2 * abs_sum);
          word.value = 17'((acc < 0) ? -quo : quo);
        end
        word.row  = 12'(r - 1);
        word.col  = 11'(c - 1);
        word.last = (r == h - 1) && (c == w - 1);
        expected_words.push_back(word);
      end

      if (c >= w - 1) begin
        col_cnt = 0;
        row_cnt = (r >= h - 1) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
        row_cnt = r;
      end
    endfunction

    function void field_check(string name, logic signed [39:0] want,
                              logic signed [39:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // compare one accepted output word with the oldest expectation
    function void check_word(logic [39:0] data, logic last, logic zk);
      conv_word_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected output word: tdata=%h tlast=%b tuser=%b", data, last, zk);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      field_check("conv_value", want.value, $signed(data[16:0]));
      field_check("out_row", want.row, data[28:17]);
      field_check("out_col", want.col, data[39:29]);
      field_check("frame_last", want.last, last);
      field_check("zero_kernel", want.zero_k, zk);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;    // [7:0] pixel
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;          // [16:0] conv_value, [28:17] out_row,
                                            // [39:29] out_col
  logic                 out_tlast;
  logic                 out_tuser;          // [0] zero_kernel
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  conv_scoreboard sb;
  bit [PIX_W-1:0] pix_q[$];
  int tx_gap_pct = 34;
  int rx_gap_pct = 34;
  int hold_left  = 0;
  int hold_req   = 0;
  int hold_ack   = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  normalized_conv3x3_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // result side: random backpressure, long hold-off on request, checking
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_ack   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        sb.check_word(out_tdata, out_tlast, out_tuser);
      end
      if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (hold_ack != hold_req) begin
        hold_left  <= HOLD_CYCLES;
        hold_ack   <= hold_ack + 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_gap_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // register write; the caller drops cfg_we after the last one
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic cfg_release();
    cfg_we <= 1'b0;
  endtask

  task automatic set_kernel(logic [CFG_W-1:0] top, logic [CFG_W-1:0] mid,
                            logic [CFG_W-1:0] bottom);
    cfg_write(REG_ROW_TOP, top);
    cfg_write(REG_ROW_MID, mid);
    cfg_write(REG_ROW_BOTTOM, bottom);
  endtask

  // stream every word of pix_q, then drop valid
  task automatic send_pixels();
    foreach (pix_q[i]) begin
      while ($urandom_range(0, 99) < tx_gap_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= pix_q[i];
      do @(posedge clk); while (!in_tready);
      sb.take_pixel(pix_q[i]);
    end
    in_tvalid <= 1'b0;
  endtask

  // wait for every expected word, then let trailing border pixels drain
  task automatic settle();
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void fill_pixels(int n, pixel_mix_t mix);
    pix_q.delete();
    repeat (n) begin
      case (mix)
        PIX_BLACK_WHITE: pix_q.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
        PIX_DARK:        pix_q.push_back(PIX_W'($urandom_range(0, 3)));
        PIX_BRIGHT:      pix_q.push_back(PIX_W'($urandom_range(250, 255)));
        default:         pix_q.push_back(PIX_W'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  function automatic logic [CFG_W-1:0] kernel_row(kernel_mix_t mix);
    logic [CFG_W-1:0] row;
    logic [COEF_BITS-1:0] edge_coefs[4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    row = CFG_W'({$urandom, $urandom});
    for (int b = 0; b < 3; b++) begin
      case (mix)
        KERN_SMALL: row[b*COEF_BITS +: COEF_BITS] = COEF_BITS'($urandom_range(0, 16) - 8);
        KERN_EDGE:  row[b*COEF_BITS +: COEF_BITS] = edge_coefs[$urandom_range(0, 3)];
        default: ;
      endcase
    end
    return row;
  endfunction

  // one random geometry and kernel, whole frames or a mid-frame shrink
  task automatic random_phase(output int sent);
    int unsigned w_reg, h_reg, n;
    kernel_mix_t kmix;
    pixel_mix_t pmix;
    logic [CFG_W-1:0] geo;
    logic [CFG_IDX_W-1:0] spare_idx;
    sent  = 0;
    w_reg = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 12);
    h_reg = $urandom_range(0, 8);
    kmix  = kernel_mix_t'($urandom_range(0, 2));
    pmix  = pixel_mix_t'($urandom_range(0, 3));

    // kernel, sometimes all zero
    if ($urandom_range(0, 7) == 0) set_kernel('0, '0, '0);
    else set_kernel(kernel_row(kmix), kernel_row(kmix), kernel_row(kmix));
    // geometry, with junk above the register width half the time
    geo = $urandom_range(0, 1) ? CFG_W'({$urandom, $urandom}) : '0;
    geo[IMG_W_BITS-1:0] = IMG_W_BITS'(w_reg);
    cfg_write(REG_IMG_WIDTH, geo);
    geo = $urandom_range(0, 1) ? CFG_W'({$urandom, $urandom}) : '0;
    geo[IMG_H_BITS-1:0] = IMG_H_BITS'(h_reg);
    cfg_write(REG_IMG_HEIGHT, geo);
    // unmapped index must be ignored
    if ($urandom_range(0, 3) == 0) begin
      spare_idx = CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI));
      cfg_write(spare_idx, CFG_W'({$urandom, $urandom}));
    end
    cfg_release();

    if ($urandom_range(0, 3) == 0 && sb.eff_width() >= 4 && sb.eff_height() >= 4) begin
      // shrink width and height in the middle of a frame
      n = $urandom_range(1, sb.eff_width() * sb.eff_height() - 1);
      fill_pixels(n, pmix);
      send_pixels();
      sent += n;
      settle();
      cfg_write(REG_IMG_WIDTH, $urandom_range(0, sb.eff_width() - 1));
      cfg_write(REG_IMG_HEIGHT, $urandom_range(0, sb.eff_height() - 1));
      cfg_release();
      n = sb.pixels_left();
    end else begin
      n = ((w_reg > 12) ? 1 : $urandom_range(1, 2)) * sb.eff_width() * sb.eff_height();
    end
    fill_pixels(n, pmix);
    send_pixels();
    sent += n;
    settle();
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    int rand_sent;
    int n;
    sb = new();
    rand_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry and zero kernel: a short run into row 0, then shrink
    // the frame to 3x3 in the middle of that row
    fill_pixels(8, PIX_ANY);
    send_pixels();
    settle();
    cfg_write(REG_IMG_WIDTH, 3);
    cfg_write(REG_IMG_HEIGHT, 3);
    cfg_release();
    fill_pixels(sb.pixels_left(), PIX_ANY);
    send_pixels();
    settle();

    // 3x6 frame: full-scale positive and negative, then rounding ties
    cfg_write(REG_IMG_WIDTH, 3);
    cfg_write(REG_IMG_HEIGHT, 6);
    set_kernel({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    cfg_release();
    pix_q.delete();
    repeat (9) pix_q.push_back(8'hFF);
    send_pixels();
    settle();
    set_kernel({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    cfg_release();
    pix_q.delete();
    repeat (3) pix_q.push_back(8'hFF);
    send_pixels();
    settle();
    // -2/1024 in Q8.8 is exactly -0.5 lsb, then +0.5 lsb
    set_kernel({16'h0000, 16'd1023, 16'hFFFF}, '0, '0);
    cfg_release();
    pix_q = '{8'd0, 8'd0, 8'd2};
    send_pixels();
    settle();
    cfg_write(REG_ROW_TOP, {16'h0000, 16'd1023, 16'h0001});
    cfg_release();
    pix_q = '{8'd0, 8'd0, 8'd2};
    send_pixels();
    settle();

    // random geometries, kernels and pixel mixes
    while (rand_sent < RANDOM_PIXELS) begin
      random_phase(n);
      rand_sent += n;
    end

    // receiver holds off while the sender keeps offering a whole frame
    set_kernel(kernel_row(KERN_FULL), kernel_row(KERN_FULL), kernel_row(KERN_FULL));
    cfg_write(REG_IMG_WIDTH, 6);
    cfg_write(REG_IMG_HEIGHT, 6);
    cfg_release();
    fill_pixels(36, PIX_ANY);
    hold_req = hold_req + 1;
    send_pixels();
    settle();

    // one frame with no idling on either side
    tx_gap_pct = 0;
    rx_gap_pct = 0;
    set_kernel(kernel_row(KERN_SMALL), kernel_row(KERN_EDGE), kernel_row(KERN_FULL));
    cfg_write(REG_IMG_WIDTH, 4);
    cfg_write(REG_IMG_HEIGHT, 12);
    cfg_release();
    fill_pixels(4 * 12, PIX_ANY);
    send_pixels();
    settle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("status: fail");
    $finish;
  end

endmodule
